// ===== rtl/lfuc_pkg.sv =====
// shared constants, op codes and types for the lfu cache with lru tie break
`timescale 1ns / 1ps
package lfuc_pkg;

   localparam int ENTRIES     = 16;
   localparam int COUNT_WIDTH = 16;
   localparam int KEY_W       = 32;
   localparam int DATA_W      = 32;
   localparam int CAP_W       = 5;
   localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W      = IDX_W;
   localparam int OCC_W       = $clog2(ENTRIES + 1);
   localparam int CMP_W       = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   localparam logic [CAP_W-1:0]       CAP_RESET = CAP_W'(16);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // request modes
   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;

   // commands broadcast to every cell
   localparam logic [1:0] OP_NOP    = 2'd0;
   localparam logic [1:0] OP_TOUCH  = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_INSERT = 2'd3;

   typedef struct packed {
      logic [1:0]        op;
      logic [IDX_W-1:0]  idx;
      logic [RANK_W-1:0] rank;
      logic              wr_value;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] value;
   } cmd_type;

   // victim candidate handed from cell to cell
   typedef struct packed {
      logic                   found;
      logic [COUNT_WIDTH-1:0] count;
      logic [RANK_W-1:0]      rank;
      logic [IDX_W-1:0]       idx;
      logic [KEY_W-1:0]       key;
   } cand_type;

   typedef struct packed {
      logic              valid;
      logic              match;
      logic [RANK_W-1:0] rank;
      logic [DATA_W-1:0] value;
   } stat_type;

endpackage

// ===== rtl/lfu_cache_lru_tiebreak.sv =====
// top level: request sequencer, occupancy, capacity register and the row of entry cells
// get, put hit, and put with zero capacity: look, decide, then respond; a new request is
// accepted only once the block is idle again. put miss with room: look, decide, insert,
// respond. put miss at capacity: look, decide, search, evict, insert, respond, the search
// lasting until the victim candidate, moving one cell per cycle, reaches the end of the cell row
// synchronous reset empties the cache and sets capacity to 16; results cannot be stalled
`timescale 1ns / 1ps
module lfu_cache_lru_tiebreak import lfuc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_mode,
   input  logic [KEY_W-1:0]         req_lookup_key,
   input  logic signed [DATA_W-1:0] req_write_value,
   output logic                     rsp_valid,
   output logic                     rsp_hit,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic                     rsp_evicted,
   output logic [KEY_W-1:0]         rsp_evicted_key,
   input  logic                     csr_write_enable,
   input  logic [CAP_W-1:0]         csr_capacity_in_use
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOOK   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_SEARCH = 3'd3;
   localparam logic [2:0] S_EVICT  = 3'd4;
   localparam logic [2:0] S_INSERT = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [CAP_W-1:0]  cap_ff;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [IDX_W-1:0]  search_cnt_ff, search_cnt_in;

   logic              mode_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [DATA_W-1:0] wvalue_ff;

   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic [RANK_W-1:0] hit_rank_ff;
   logic [DATA_W-1:0] hit_value_ff;
   logic [DATA_W-1:0] read_value_ff, read_value_in;
   logic              evicted_ff, evicted_in;
   logic [KEY_W-1:0]  evicted_key_ff, evicted_key_in;

   cmd_type           cmd;
   cand_type          chain [0:ENTRIES];
   stat_type          stat [ENTRIES];

   logic              hit_any;
   logic [IDX_W-1:0]  hit_idx;
   logic [RANK_W-1:0] hit_rank;
   logic [DATA_W-1:0] hit_value;
   logic              free_any;
   logic [IDX_W-1:0]  free_idx;
   logic [CMP_W-1:0]  cap_eff;
   logic [CMP_W-1:0]  occ_ext;

   assign chain[0] = '0;

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         lfuc_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .cell_idx (IDX_W'(g)),
            .cmd      (cmd),
            .cand_in  (chain[g]),
            .cand_out (chain[g+1]),
            .stat     (stat[g])
         );
      end
   endgenerate

   // at most one cell matches, so an and-or gather is enough
   always_comb begin
      hit_any   = 1'b0;
      hit_idx   = '0;
      hit_rank  = '0;
      hit_value = '0;
      free_any  = 1'b0;
      free_idx  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (stat[i].match) begin
            hit_any   = 1'b1;
            hit_idx   = hit_idx | IDX_W'(i);
            hit_rank  = hit_rank | stat[i].rank;
            hit_value = hit_value | stat[i].value;
         end
      end
      // lowest free slot
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!stat[i].valid) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   assign occ_ext = CMP_W'(occ_ff);
   assign cap_eff = (CMP_W'(cap_ff) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(cap_ff);

   always_comb begin
      state_in       = state_ff;
      occ_in         = occ_ff;
      search_cnt_in  = search_cnt_ff;
      hit_in         = hit_ff;
      read_value_in  = read_value_ff;
      evicted_in     = evicted_ff;
      evicted_key_in = evicted_key_ff;
      cmd.op         = OP_NOP;
      cmd.idx        = hit_idx_ff;
      cmd.rank       = hit_rank_ff;
      cmd.wr_value   = 1'b0;
      cmd.key        = key_ff;
      cmd.value      = wvalue_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_LOOK;
         end
         S_LOOK: begin
            hit_in         = hit_any;
            read_value_in  = '0;
            evicted_in     = 1'b0;
            evicted_key_in = '0;
            state_in       = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_RESP;
            if (mode_ff == MODE_GET) begin
               if (hit_ff) begin
                  cmd.op        = OP_TOUCH;
                  read_value_in = hit_value_ff;
               end
            end else if (cap_eff != '0) begin
               if (hit_ff) begin
                  cmd.op       = OP_TOUCH;
                  cmd.wr_value = 1'b1;
               end else if (occ_ext >= cap_eff) begin
                  search_cnt_in = '0;
                  state_in      = S_SEARCH;
               end else begin
                  state_in = S_INSERT;
               end
            end
         end
         S_SEARCH: begin
            // the row is stable, wait until the best candidate reaches its end
            search_cnt_in = search_cnt_ff + 1'b1;
            if (search_cnt_ff == IDX_W'(ENTRIES - 1)) state_in = S_EVICT;
         end
         S_EVICT: begin
            if (chain[ENTRIES].found) begin
               cmd.op         = OP_REMOVE;
               cmd.idx        = chain[ENTRIES].idx;
               cmd.rank       = chain[ENTRIES].rank;
               evicted_in     = 1'b1;
               evicted_key_in = chain[ENTRIES].key;
               if (occ_ff != '0) occ_in = occ_ff - 1'b1;
            end
            state_in = S_INSERT;
         end
         S_INSERT: begin
            if (free_any) begin
               cmd.op  = OP_INSERT;
               cmd.idx = free_idx;
               occ_in  = occ_ff + 1'b1;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         occ_ff   <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         if (csr_write_enable) cap_ff <= csr_capacity_in_use;
      end
      if (state_ff == S_IDLE) begin
         mode_ff   <= req_mode;
         key_ff    <= req_lookup_key;
         wvalue_ff <= req_write_value;
      end
      if (state_ff == S_LOOK) begin
         hit_idx_ff   <= hit_idx;
         hit_rank_ff  <= hit_rank;
         hit_value_ff <= hit_value;
      end
      search_cnt_ff  <= search_cnt_in;
      hit_ff         <= hit_in;
      read_value_ff  <= read_value_in;
      evicted_ff     <= evicted_in;
      evicted_key_ff <= evicted_key_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = (state_ff == S_RESP);
   assign rsp_hit         = hit_ff;
   assign rsp_read_value  = read_value_ff;
   assign rsp_evicted     = evicted_ff;
   assign rsp_evicted_key = evicted_key_ff;

endmodule

// ===== rtl/lfuc_cell.sv =====
// one cache entry: key, value, use count, recency rank and a victim search stage
`timescale 1ns / 1ps
module lfuc_cell import lfuc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_idx,
   input  cmd_type          cmd,
   input  cand_type         cand_in,
   output cand_type         cand_out,
   output stat_type         stat
);

   logic                   valid_ff, valid_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [DATA_W-1:0]      value_ff, value_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [RANK_W-1:0]      rank_ff, rank_in;
   cand_type               cand_ff, cand_next_in;
   logic                   sel;
   logic                   own_better;

   assign sel = (cmd.idx == cell_idx);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      count_in = count_ff;
      rank_in  = rank_ff;
      case (cmd.op)
         OP_TOUCH: begin
            if (sel) begin
               rank_in = '0;
               if (count_ff != COUNT_MAX) count_in = count_ff + 1'b1;
               if (cmd.wr_value) value_in = cmd.value;
            end else if (valid_ff && rank_ff < cmd.rank) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         OP_REMOVE: begin
            if (sel) begin
               valid_in = 1'b0;
            end else if (valid_ff && rank_ff > cmd.rank) begin
               rank_in = rank_ff - 1'b1;
            end
         end
         OP_INSERT: begin
            if (sel) begin
               valid_in = 1'b1;
               key_in   = cmd.key;
               value_in = cmd.value;
               count_in = COUNT_WIDTH'(1);
               rank_in  = '0;
            end else if (valid_ff) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   // lowest count wins, older (higher rank) wins among equal counts
   assign own_better = valid_ff &&
      (!cand_in.found || count_ff < cand_in.count ||
       (count_ff == cand_in.count && rank_ff > cand_in.rank));

   always_comb begin
      if (own_better) begin
         cand_next_in.found = 1'b1;
         cand_next_in.count = count_ff;
         cand_next_in.rank  = rank_ff;
         cand_next_in.idx   = cell_idx;
         cand_next_in.key   = key_ff;
      end else begin
         cand_next_in = cand_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         cand_ff.found <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         cand_ff.found <= cand_next_in.found;
      end
      key_ff        <= key_in;
      value_ff      <= value_in;
      count_ff      <= count_in;
      rank_ff       <= rank_in;
      cand_ff.count <= cand_next_in.count;
      cand_ff.rank  <= cand_next_in.rank;
      cand_ff.idx   <= cand_next_in.idx;
      cand_ff.key   <= cand_next_in.key;
   end

   assign cand_out    = cand_ff;
   assign stat.valid  = valid_ff;
   assign stat.match  = valid_ff && (key_ff == cmd.key);
   assign stat.rank   = rank_ff;
   assign stat.value  = value_ff;

endmodule

// ===== rtl/lfuc_checker.sv =====
// port-level checks for the lfu cache, bound to the top level
`timescale 1ns / 1ps
module lfuc_checker import lfuc_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_valid,
   input logic                     rsp_hit,
   input logic signed [DATA_W-1:0] rsp_read_value,
   input logic                     rsp_evicted,
   input logic [KEY_W-1:0]         rsp_evicted_key
);

   // an accepted request keeps the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // a result only appears while a request is in flight
   a_rsp_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside a request");

   // one result per request: the strobe falls again after each result
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // eviction only on a put miss, which returns no value
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> !rsp_hit && rsp_read_value == 0)
      else $error("eviction reported with a hit or a value");

   a_evict_key_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted |-> rsp_evicted_key == '0)
      else $error("evicted key nonzero without eviction");

endmodule

bind lfu_cache_lru_tiebreak lfuc_checker u_lfuc_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_hit         (rsp_hit),
   .rsp_read_value  (rsp_read_value),
   .rsp_evicted     (rsp_evicted),
   .rsp_evicted_key (rsp_evicted_key)
);

// ===== tb/sv/lfuc_tb_pkg.sv =====
// request kinds, response record and the shadow lfu cache that predicts each response
`timescale 1ns / 1ps
package lfuc_tb_pkg;
   import lfuc_pkg::*;

   typedef enum bit {REQ_GET = MODE_GET, REQ_PUT = MODE_PUT} req_kind_type;

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] read_value;
      logic              evicted;
      logic [KEY_W-1:0]  evicted_key;
   } lookup_answer_type;

   class lfu_cache_shadow;
      bit                     occupied[ENTRIES];
      logic [KEY_W-1:0]       slot_key[ENTRIES];
      logic [DATA_W-1:0]      slot_value[ENTRIES];
      logic [COUNT_WIDTH-1:0] slot_uses[ENTRIES];
      logic [RANK_W-1:0]      slot_age[ENTRIES];
      logic [OCC_W-1:0]       occupancy;
      logic [CAP_W-1:0]       capacity;
      lookup_answer_type      answers_due[$];
      int                     errors;

      function new();
         capacity  = CAP_RESET;
         occupancy = '0;
         errors    = 0;
         foreach (occupied[i]) occupied[i] = 1'b0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] c);
         capacity = c;
      endfunction

      function int pending();
         return answers_due.size();
      endfunction

      // touched entry becomes age 0 and gains a use, the entries younger than it age by one
      function void touch(int s);
         foreach (occupied[i])
            if (occupied[i] && i != s && slot_age[i] < slot_age[s]) slot_age[i]++;
         slot_age[s] = '0;
         if (slot_uses[s] != COUNT_MAX) slot_uses[s]++;
      endfunction

      function void accept_request(req_kind_type kind, logic [KEY_W-1:0] k,
                                   logic [DATA_W-1:0] v);
         int                found;
         int                victim;
         int                free_slot;
         int                limit;
         lookup_answer_type ans;
         found = -1;
         foreach (occupied[i])
            if (found < 0 && occupied[i] && slot_key[i] === k) found = i;
         ans     = '0;
         ans.hit = (found >= 0);
         limit   = (capacity > ENTRIES) ? ENTRIES : capacity;
         if (kind == REQ_GET) begin
            if (found >= 0) begin
               ans.read_value = slot_value[found];
               touch(found);
            end
         end else if (limit != 0) begin
            if (found >= 0) begin
               slot_value[found] = v;
               touch(found);
            end else begin
               if (occupancy >= limit) begin
                  // lowest count wins, the oldest among equal counts
                  victim = -1;
                  foreach (occupied[i])
                     if (occupied[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                         (slot_uses[i] == slot_uses[victim] &&
                          slot_age[i] > slot_age[victim])))
                        victim = i;
                  ans.evicted      = 1'b1;
                  ans.evicted_key  = slot_key[victim];
                  occupied[victim] = 1'b0;
                  foreach (occupied[i])
                     if (occupied[i] && slot_age[i] > slot_age[victim]) slot_age[i]--;
                  occupancy--;
               end
               free_slot = -1;
               foreach (occupied[i])
                  if (free_slot < 0 && !occupied[i]) free_slot = i;
               foreach (occupied[i])
                  if (occupied[i]) slot_age[i]++;
               occupied[free_slot]   = 1'b1;
               slot_key[free_slot]   = k;
               slot_value[free_slot] = v;
               slot_uses[free_slot]  = COUNT_WIDTH'(1);
               slot_age[free_slot]   = '0;
               occupancy++;
            end
         end
         answers_due.push_back(ans);
      endfunction

      task report(string msg);
         errors++;
         $display("error: %s", msg);
      endtask

      task compare_response(logic hit, logic [DATA_W-1:0] rv, logic ev,
                            logic [KEY_W-1:0] ek);
         lookup_answer_type want;
         if (answers_due.size() == 0) begin
            report("response with no request outstanding");
         end else begin
            want = answers_due.pop_front();
            if (hit !== want.hit)
               report($sformatf("hit %b, expected %b", hit, want.hit));
            if (rv !== want.read_value)
               report($sformatf("read_value %h, expected %h", rv, want.read_value));
            if (ev !== want.evicted)
               report($sformatf("evicted %b, expected %b", ev, want.evicted));
            if (ek !== want.evicted_key)
               report($sformatf("evicted_key %h, expected %h", ek, want.evicted_key));
         end
      endtask
   endclass

endpackage

// ===== tb/sv/tb_lfu_cache_lru_tiebreak.sv =====
// top level testbench for the lfu cache with lru tie break
`timescale 1ns / 1ps
module tb_lfu_cache_lru_tiebreak;
   import lfuc_pkg::*;
   import lfuc_tb_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int POOL        = 32;

   localparam logic [KEY_W-1:0]  KEY_LOW  = '0;
   localparam logic [KEY_W-1:0]  KEY_HIGH = '1;
   localparam logic [KEY_W-1:0]  KEY_B    = 32'h5A5A_0001;
   localparam logic [KEY_W-1:0]  KEY_C    = 32'hC3C3_0002;
   localparam logic [KEY_W-1:0]  KEY_D    = 32'h1234_5678;
   localparam logic [KEY_W-1:0]  KEY_E    = 32'h8000_0000;
   localparam logic [KEY_W-1:0]  KEY_F    = 32'h0000_0001;
   localparam logic [KEY_W-1:0]  KEY_G    = 32'h7FFF_FFFF;
   localparam logic [KEY_W-1:0]  KEY_H    = 32'hDEAD_0009;
   localparam logic [DATA_W-1:0] DATA_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] DATA_MIN = 32'h8000_0000;

   logic                     clock               = 1'b0;
   logic                     reset               = 1'b1;
   logic                     start               = 1'b0;
   logic                     busy;
   logic                     req_mode            = 1'b0;
   logic [KEY_W-1:0]         req_lookup_key      = '0;
   logic signed [DATA_W-1:0] req_write_value     = '0;
   logic                     rsp_valid;
   logic                     rsp_hit;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic                     rsp_evicted;
   logic [KEY_W-1:0]         rsp_evicted_key;
   logic                     csr_write_enable    = 1'b0;
   logic [CAP_W-1:0]         csr_capacity_in_use = CAP_RESET;

   lfu_cache_shadow  cache_model;
   logic [KEY_W-1:0] key_pool[POOL];
   int               cycle_count = 0;

   lfu_cache_lru_tiebreak dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_lookup_key     (req_lookup_key),
      .req_write_value    (req_write_value),
      .rsp_valid          (rsp_valid),
      .rsp_hit            (rsp_hit),
      .rsp_read_value     (rsp_read_value),
      .rsp_evicted        (rsp_evicted),
      .rsp_evicted_key    (rsp_evicted_key),
      .csr_write_enable   (csr_write_enable),
      .csr_capacity_in_use(csr_capacity_in_use)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         cache_model.compare_response(rsp_hit, rsp_read_value, rsp_evicted, rsp_evicted_key);
   end

   // start stays high on return so back-to-back requests keep it asserted
   task automatic send_request(req_kind_type kind, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
      start           <= 1'b1;
      req_mode        <= (kind == REQ_PUT);
      req_lookup_key  <= k;
      req_write_value <= v;
      do @(posedge clock); while (busy);
      cache_model.accept_request(kind, k, v);
   endtask

   task automatic pause_requests(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] c);
      start <= 1'b0;
      do @(posedge clock); while (cache_model.pending() != 0 || busy);
      csr_write_enable    <= 1'b1;
      csr_capacity_in_use <= c;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cache_model.set_capacity(c);
   endtask

   task automatic random_phase(logic [CAP_W-1:0] c, int n, bit with_gaps);
      int               pick;
      logic [KEY_W-1:0] k;
      write_capacity(c);
      for (int j = 0; j < n; j++) begin
         if (with_gaps && $urandom_range(0, 3) == 0) pause_requests($urandom_range(1, 19));
         // a few hot keys, a wider pool that overflows the cache, and fresh keys
         pick = $urandom_range(0, 99);
         if (pick < 40)
            k = key_pool[$urandom_range(0, 5)];
         else if (pick < 85)
            k = key_pool[$urandom_range(0, POOL - 1)];
         else
            k = $urandom;
         send_request(req_kind_type'($urandom_range(0, 1)), k, $urandom);
      end
   endtask

   initial begin
      int wait_cycles;
      cache_model = new();
      foreach (key_pool[i]) key_pool[i] = $urandom;
      key_pool[0] = KEY_LOW;
      key_pool[1] = KEY_HIGH;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      write_capacity(CAP_W'(2));
      send_request(REQ_GET, KEY_LOW, DATA_MAX);
      send_request(REQ_PUT, KEY_LOW, DATA_MAX);
      send_request(REQ_PUT, KEY_HIGH, DATA_MIN);
      send_request(REQ_GET, KEY_LOW, '0);
      send_request(REQ_GET, KEY_HIGH, '1);
      send_request(REQ_PUT, KEY_LOW, '1);
      send_request(REQ_GET, KEY_LOW, '0);
      send_request(REQ_PUT, KEY_B, 32'h0000_0001);
      send_request(REQ_PUT, KEY_C, 32'h1111_2222);
      repeat (3) send_request(REQ_GET, KEY_C, $urandom);
      // equal counts: the older entry goes
      send_request(REQ_PUT, KEY_D, 32'h3333_4444);
      send_request(REQ_PUT, KEY_H, 32'h5555_6666);

      write_capacity(CAP_W'(0));
      send_request(REQ_PUT, KEY_E, 32'h0F0F_0F0F);
      send_request(REQ_PUT, KEY_H, 32'hFFFF_0000);
      send_request(REQ_GET, KEY_H, '0);
      write_capacity(CAP_W'(31));
      send_request(REQ_PUT, KEY_F, 32'hF0F0_F0F0);
      send_request(REQ_GET, KEY_F, '1);
      // capacity now below occupancy
      write_capacity(CAP_W'(2));
      send_request(REQ_PUT, KEY_G, 32'hAAAA_5555);

      random_phase(CAP_W'(16), 90, 1'b1);
      random_phase(CAP_W'(5), 80, 1'b1);
      random_phase(CAP_W'(1), 60, 1'b1);
      random_phase(CAP_W'(0), 40, 1'b1);
      random_phase(CAP_W'(12), 80, 1'b1);
      random_phase(CAP_W'(31), 80, 1'b1);
      random_phase(CAP_W'(3), 70, 1'b1);
      random_phase(CAP_W'($urandom_range(2, 16)), 80, 1'b1);
      random_phase(CAP_W'(16), 70, 1'b0);

      start <= 1'b0;
      wait_cycles = 0;
      while (cache_model.pending() != 0 && wait_cycles < 200) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (30) @(posedge clock);
      if (cache_model.pending() != 0)
         cache_model.report($sformatf("%0d requests never answered", cache_model.pending()));
      if (cache_model.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/lfuc_pkg.sv
rtl/lfuc_cell.sv
rtl/lfu_cache_lru_tiebreak.sv
rtl/lfuc_checker.sv
tb/sv/lfuc_tb_pkg.sv
tb/sv/tb_lfu_cache_lru_tiebreak.sv
